[rtl/core/csb_pkg.sv]
package csb_pkg;

    // Default store depths and largest block side.
    localparam int DEF_MAX_ROWS  = 4096;
    localparam int DEF_MAX_COLS  = 4096;
    localparam int DEF_MAX_BLOCK = 64;

    // Field widths of the request and response items.
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 12;
    localparam int LOC_W  = 6;
    localparam int VAL_W  = 32;
    localparam int Y_W    = 48;

    // Configuration register widths.
    localparam int CNT_W  = 13;
    localparam int BS_W   = 7;

    // Global row and column: block index times beta plus local offset.
    localparam int GIDX_W = IDX_W + BS_W + 1;

    // Configuration bus.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_X = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_READ_Y = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] column_count;
        logic [BS_W-1:0]  block_size;
    } cfg_t;

endpackage

[rtl/core/csb_if.sv]
interface csb_req_if;
    import csb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         vector_index;
    logic [IDX_W-1:0]         row_block;
    logic [IDX_W-1:0]         block_column;
    logic [LOC_W-1:0]         row_offset;
    logic [LOC_W-1:0]         local_column;
    logic signed [VAL_W-1:0]  data_value;

    modport source (
        output valid, cmd, vector_index, row_block, block_column,
               row_offset, local_column, data_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, vector_index, row_block, block_column,
               row_offset, local_column, data_value,
        output ready
    );
endinterface

interface csb_rsp_if;
    import csb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        result_index;
    logic signed [Y_W-1:0]   result_value;

    modport source (
        output valid, result_index, result_value,
        input  ready
    );

    modport sink (
        input  valid, result_index, result_value,
        output ready
    );
endinterface

[rtl/core/csb_cfg.sv]
module csb_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csb_pkg::PADDR_W-1:0]  paddr,
    input  logic [csb_pkg::PDATA_W-1:0]  pwdata,
    output logic [csb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output csb_pkg::cfg_t                cfg
);
    import csb_pkg::*;

    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register update on the access phase of a write transfer.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_COUNT:    cfg_next.row_count    = pwdata[CNT_W-1:0];
                REG_COLUMN_COUNT: cfg_next.column_count = pwdata[CNT_W-1:0];
                REG_BLOCK_SIZE:   cfg_next.block_size   = pwdata[BS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count    <= CNT_W'(1);
            cfg_reg.column_count <= CNT_W'(1);
            cfg_reg.block_size   <= BS_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back of the selected register.
    always_comb
    begin
        case (reg_sel)
            REG_ROW_COUNT:    prdata = PDATA_W'(cfg_reg.row_count);
            REG_COLUMN_COUNT: prdata = PDATA_W'(cfg_reg.column_count);
            REG_BLOCK_SIZE:   prdata = PDATA_W'(cfg_reg.block_size);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/core/csb_mac.sv]
module csb_mac (
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [csb_pkg::VAL_W-1:0]   data_value,
    input  logic signed [csb_pkg::VAL_W-1:0]   x_value,
    input  logic signed [csb_pkg::Y_W-1:0]     y_value,
    output logic signed [csb_pkg::Y_W-1:0]     y_sum
);
    import csb_pkg::*;

    localparam int PROD_W = 2 * VAL_W;
    localparam int FRAC_W = 16;
    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_full;
    logic signed [Y_W-1:0]    prod_next;
    logic signed [Y_W-1:0]    prod_reg;
    logic signed [Y_W:0]      sum_wide;

    // Q16.16 times Q16.16; dropping the low 16 bits floors towards minus infinity.
    assign prod_full = PROD_W'(data_value) * PROD_W'(x_value);
    assign prod_next = prod_full[FRAC_W +: Y_W];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate into the Q32.16 element and clamp on overflow.
    assign sum_wide = {y_value[Y_W-1], y_value} + {prod_reg[Y_W-1], prod_reg};

    always_comb
    begin
        if (sum_wide[Y_W] != sum_wide[Y_W-1])
        begin
            y_sum = sum_wide[Y_W] ? Y_MIN : Y_MAX;
        end
        else
        begin
            y_sum = sum_wide[Y_W-1:0];
        end
    end

endmodule

[rtl/core/csb_sparse_matvec_accumulate.sv]
// Channel    Role    Moves                                   Transfer when
// request    sink    cmd, index, block coords, data_value    valid && ready
// response   source  result_index, result_value              valid && ready
// APB        slave   row_count, column_count, block_size     psel && penable && pwrite
//
// A load of x is taken in the idle state; a nonzero passes through the address, multiply
// and accumulate states (only the address state when it falls outside the matrix);
// a read of y passes through the output state, in a single-issue sequencer around the
// registered x and y memory reads and the product register. After reset a clearing pass
// zeroes both memories over max(MAX_ROWS, MAX_COLS) addresses (4096 by default);
// request.ready stays low meanwhile, APB writes are taken. A response waits in its
// output register while further requests are taken; a read of y that finds it still
// full holds the sequencer and request.ready low until the waiting response transfers.
module csb_sparse_matvec_accumulate #(
    parameter int MAX_ROWS  = csb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = csb_pkg::DEF_MAX_COLS,
    parameter int MAX_BLOCK = csb_pkg::DEF_MAX_BLOCK
) (
    input  logic                         clk,
    input  logic                         rst_n,
    csb_req_if.sink                      request,
    csb_rsp_if.source                    response,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csb_pkg::PADDR_W-1:0]  paddr,
    input  logic [csb_pkg::PDATA_W-1:0]  pwdata,
    output logic [csb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import csb_pkg::*;

    localparam int YA_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XA_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CLR_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_MUL,
        S_ACC,
        S_YOUT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]        vector_index;
        logic [IDX_W-1:0]        row_block;
        logic [IDX_W-1:0]        block_column;
        logic [LOC_W-1:0]        row_offset;
        logic [LOC_W-1:0]        local_column;
        logic signed [VAL_W-1:0] data_value;
    } item_t;

    cfg_t                    cfg;
    state_t                  state_reg;
    state_t                  state_next;
    logic [CLR_W-1:0]        clr_cnt_reg;
    logic [CLR_W-1:0]        clr_cnt_next;
    item_t                   item_reg;
    logic [GIDX_W-1:0]       gr_reg;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic [IDX_W-1:0]        rsp_index_reg;
    logic [IDX_W-1:0]        rsp_index_next;
    logic signed [Y_W-1:0]   rsp_value_reg;
    logic signed [Y_W-1:0]   rsp_value_next;

    logic                    req_fire;
    logic                    out_free;
    logic                    x_idx_ok;
    logic                    y_idx_ok;
    logic                    y_item_ok;

    logic [BS_W-1:0]         beta;
    logic [CNT_W-1:0]        rlim;
    logic [CNT_W-1:0]        clim;
    logic [GIDX_W-1:0]       gr;
    logic [GIDX_W-1:0]       gc;
    logic                    hit;

    logic [VAL_W-1:0]        x_mem [MAX_COLS];
    logic signed [Y_W-1:0]   y_mem [MAX_ROWS];
    logic                    x_we;
    logic [XA_W-1:0]         x_waddr;
    logic [VAL_W-1:0]        x_wdata;
    logic                    x_re;
    logic [XA_W-1:0]         x_raddr;
    logic [VAL_W-1:0]        x_rdata_reg;
    logic                    y_we;
    logic [YA_W-1:0]         y_waddr;
    logic signed [Y_W-1:0]   y_wdata;
    logic                    y_re;
    logic [YA_W-1:0]         y_raddr;
    logic signed [Y_W-1:0]   y_rdata_reg;
    logic signed [Y_W-1:0]   y_sum;

    csb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csb_mac u_mac (
        .clk        (clk),
        .load       (state_reg == S_MUL),
        .data_value (item_reg.data_value),
        .x_value    ($signed(x_rdata_reg)),
        .y_value    (y_rdata_reg),
        .y_sum      (y_sum)
    );

    assign request.ready         = (state_reg == S_IDLE);
    assign req_fire              = request.valid & request.ready;
    assign out_free              = !rsp_valid_reg || response.ready;
    assign response.valid        = rsp_valid_reg;
    assign response.result_index = rsp_index_reg;
    assign response.result_value = rsp_value_reg;

    assign x_idx_ok  = 32'(request.vector_index) < 32'(MAX_COLS);
    assign y_idx_ok  = 32'(request.vector_index) < 32'(MAX_ROWS);
    assign y_item_ok = 32'(item_reg.vector_index) < 32'(MAX_ROWS);

    // Global coordinates of the held nonzero and the matrix bounds check.
    always_comb
    begin
        beta = (32'(cfg.block_size) > 32'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : cfg.block_size;
        rlim = (32'(cfg.row_count) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cfg.row_count;
        clim = (32'(cfg.column_count) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                       : cfg.column_count;
        gr   = GIDX_W'(item_reg.row_block) * GIDX_W'(beta) + GIDX_W'(item_reg.row_offset);
        gc   = GIDX_W'(item_reg.block_column) * GIDX_W'(beta)
             + GIDX_W'(item_reg.local_column);
        hit  = (gr < GIDX_W'(rlim)) && (gc < GIDX_W'(clim));
    end

    // Memory port control: clearing pass, loads, reads and write-back.
    always_comb
    begin
        x_we    = 1'b0;
        x_waddr = XA_W'(clr_cnt_reg);
        x_wdata = '0;
        x_re    = 1'b0;
        x_raddr = XA_W'(gc);
        y_we    = 1'b0;
        y_waddr = YA_W'(clr_cnt_reg);
        y_wdata = '0;
        y_re    = 1'b0;
        y_raddr = YA_W'(gr);
        case (state_reg)
            S_CLEAR:
            begin
                x_we = 32'(clr_cnt_reg) < 32'(MAX_COLS);
                y_we = 32'(clr_cnt_reg) < 32'(MAX_ROWS);
            end
            S_IDLE:
            begin
                if (req_fire && (request.cmd == CMD_LOAD_X))
                begin
                    x_we    = x_idx_ok;
                    x_waddr = XA_W'(request.vector_index);
                    x_wdata = request.data_value;
                end
                if (req_fire && (request.cmd == CMD_READ_Y))
                begin
                    y_re    = y_idx_ok;
                    y_raddr = YA_W'(request.vector_index);
                end
            end
            S_ADDR:
            begin
                x_re = hit;
                y_re = hit;
            end
            S_ACC:
            begin
                y_we    = 1'b1;
                y_waddr = YA_W'(gr_reg);
                y_wdata = y_sum;
            end
            S_YOUT:
            begin
                y_we    = out_free && y_item_ok;
                y_waddr = YA_W'(item_reg.vector_index);
            end
            default:
            begin
                x_we = 1'b0;
            end
        endcase
    end

    // Vector store x.
    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[x_waddr] <= x_wdata;
        end
        if (x_re)
        begin
            x_rdata_reg <= x_mem[x_raddr];
        end
    end

    // Accumulator store y.
    always_ff @(posedge clk)
    begin
        if (y_we)
        begin
            y_mem[y_waddr] <= y_wdata;
        end
        if (y_re)
        begin
            y_rdata_reg <= y_mem[y_raddr];
        end
    end

    // Held request item.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.vector_index <= request.vector_index;
            item_reg.row_block    <= request.row_block;
            item_reg.block_column <= request.block_column;
            item_reg.row_offset   <= request.row_offset;
            item_reg.local_column <= request.local_column;
            item_reg.data_value   <= request.data_value;
        end
        if (state_reg == S_ADDR)
        begin
            gr_reg <= gr;
        end
    end

    // Sequencer next state and response register.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !response.ready;
        rsp_index_next = rsp_index_reg;
        rsp_value_next = rsp_value_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire && (request.cmd == CMD_ACCUM))
                begin
                    state_next = S_ADDR;
                end
                else if (req_fire && (request.cmd == CMD_READ_Y))
                begin
                    state_next = S_YOUT;
                end
            end
            S_ADDR:
            begin
                state_next = hit ? S_MUL : S_IDLE;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_IDLE;
            end
            S_YOUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_index_next = item_reg.vector_index;
                    rsp_value_next = y_item_ok ? y_rdata_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_index_reg <= '0;
            rsp_value_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_index_reg <= rsp_index_next;
            rsp_value_reg <= rsp_value_next;
        end
    end

endmodule

[rtl/core/csb_checker.sv]
module csb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic [csb_pkg::CMD_W-1:0]        req_cmd,
    input logic [csb_pkg::IDX_W-1:0]        req_index,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [csb_pkg::IDX_W-1:0]        rsp_index,
    input logic signed [csb_pkg::Y_W-1:0]   rsp_value
);
    import csb_pkg::*;

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index) && $stable(rsp_value))
        else $error("response changed while stalled");

    // A fresh response follows a read transfer, by way of the output state and the response register.
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_cmd == CMD_READ_Y), 2))
        else $error("response without a read of y");

    // That response echoes the index of the read.
    a_rsp_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> rsp_index == $past(req_index, 2))
        else $error("response index differs from the read index");

    // Accumulate and read transfers take the sequencer out of the idle state, so request.ready drops.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_cmd == CMD_ACCUM || req_cmd == CMD_READ_Y)
        |=> !req_ready)
        else $error("request taken while the sequencer is busy");

endmodule

bind csb_sparse_matvec_accumulate csb_checker u_csb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_cmd   (request.cmd),
    .req_index (request.vector_index),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .rsp_index (response.result_index),
    .rsp_value (response.result_value)
);

[tb/csb_sparse_matvec_accumulate_tb.sv]
`timescale 1ns / 100ps

module csb_sparse_matvec_accumulate_tb;
    import csb_pkg::*;

    // Command code that the block leaves unused, and register indexes.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int REG_ROW_COUNT    = 0;
    localparam int REG_COLUMN_COUNT = 1;
    localparam int REG_BLOCK_SIZE   = 2;

    localparam logic signed [63:0] Y_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] Y_BOTTOM = -Y_TOP - 64'sd1;
    localparam logic signed [Y_W-1:0] Y_SAT_HIGH = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [Y_W-1:0] Y_SAT_LOW  = 48'sh8000_0000_0000;
    localparam logic signed [Y_W-1:0] Y_MINUS_ONE = 48'shFFFF_FFFF_FFFF;

    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int LONG_HOLD       = 400;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        vector_index;
        logic [IDX_W-1:0]        row_block;
        logic [IDX_W-1:0]        block_column;
        logic [LOC_W-1:0]        row_offset;
        logic [LOC_W-1:0]        local_column;
        logic signed [VAL_W-1:0] data_value;
    } spmv_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic signed [Y_W-1:0] value;
    } y_read_t;

    // One line of the directed stimulus: either a register write or an item.
    typedef struct {
        bit                    is_cfg;
        int                    reg_idx;
        logic [PDATA_W-1:0]    reg_value;
        spmv_req_t             item;
        bit                    typed;
        logic signed [Y_W-1:0] typed_value;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    csb_req_if req_ch ();
    csb_rsp_if rsp_ch ();

    csb_sparse_matvec_accumulate dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted block state and configuration.
    logic signed [VAL_W-1:0] x_model [DEF_MAX_COLS];
    logic signed [Y_W-1:0]   y_model [DEF_MAX_ROWS];
    int unsigned cfg_rows;
    int unsigned cfg_cols;
    int unsigned cfg_block;

    // Read results still to come back, oldest first.
    y_read_t pending_reads[$];

    int fail_count;
    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int n_loads;
    int n_accum;
    int n_reads;
    int n_unused;
    int n_dropped;
    int n_checked;
    int n_settings;

    directed_row_t directed[$];

    // Clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor: applies one accepted item to the model state.
    function automatic void spmv_predict(input spmv_req_t it, output bit produces,
                                         output y_read_t res);
        int unsigned beta;
        int unsigned rlim;
        int unsigned clim;
        int unsigned grow;
        int unsigned gcol;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        produces = 1'b0;
        res = '0;
        case (it.cmd)
            CMD_LOAD_X:
            begin
                x_model[it.vector_index] = it.data_value;
            end
            CMD_ACCUM:
            begin
                beta = (cfg_block > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : cfg_block;
                rlim = (cfg_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cfg_rows;
                clim = (cfg_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cfg_cols;
                grow = it.row_block * beta + it.row_offset;
                gcol = it.block_column * beta + it.local_column;
                if (grow >= rlim || gcol >= clim)
                begin
                    n_dropped++;
                end
                else
                begin
                    lhs = 64'(it.data_value);
                    rhs = 64'(x_model[gcol]);
                    prod = (lhs * rhs) >>> 16;
                    sum = y_model[grow] + prod;
                    if (sum > Y_TOP)
                        sum = Y_TOP;
                    else if (sum < Y_BOTTOM)
                        sum = Y_BOTTOM;
                    y_model[grow] = sum[Y_W-1:0];
                end
            end
            CMD_READ_Y:
            begin
                produces = 1'b1;
                res.index = it.vector_index;
                res.value = y_model[it.vector_index];
                y_model[it.vector_index] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic directed_row_t row_item(logic [CMD_W-1:0] cmd,
                                               logic [IDX_W-1:0] vi,
                                               logic [IDX_W-1:0] br,
                                               logic [IDX_W-1:0] bc,
                                               logic [LOC_W-1:0] lr,
                                               logic [LOC_W-1:0] lc,
                                               logic [VAL_W-1:0] dv,
                                               bit typed = 1'b0,
                                               logic [Y_W-1:0] tv = '0);
        directed_row_t r;
        r.is_cfg = 1'b0;
        r.reg_idx = 0;
        r.reg_value = '0;
        r.item = '{cmd, vi, br, bc, lr, lc, dv};
        r.typed = typed;
        r.typed_value = tv;
        return r;
    endfunction

    function automatic directed_row_t row_cfg(int reg_idx, logic [PDATA_W-1:0] value);
        directed_row_t r;
        r.is_cfg = 1'b1;
        r.reg_idx = reg_idx;
        r.reg_value = value;
        r.item = '0;
        r.typed = 1'b0;
        r.typed_value = '0;
        return r;
    endfunction

    // Offers one item on the request channel, starting and ending at a falling edge.
    task automatic offer(input spmv_req_t it, input bit typed,
                         input logic signed [Y_W-1:0] typed_value);
        bit produces;
        y_read_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= it.cmd;
        req_ch.vector_index <= it.vector_index;
        req_ch.row_block    <= it.row_block;
        req_ch.block_column <= it.block_column;
        req_ch.row_offset   <= it.row_offset;
        req_ch.local_column <= it.local_column;
        req_ch.data_value   <= it.data_value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        spmv_predict(it, produces, res);
        if (produces)
        begin
            if (typed)
                res.value = typed_value;
            pending_reads.push_back(res);
        end
        case (it.cmd)
            CMD_LOAD_X: n_loads++;
            CMD_ACCUM:  n_accum++;
            CMD_READ_Y: n_reads++;
            default:    n_unused++;
        endcase
        @(negedge clk);
    endtask

    // Stops offering and waits until every read result has come back.
    task automatic drain_reads();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reads.size() != 0);
    endtask

    // Lets the block go idle, then writes one register with a setup phase and an access phase.
    task automatic cfg_write(input int reg_idx, input logic [PDATA_W-1:0] value);
        drain_reads();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(reg_idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (reg_idx)
            REG_ROW_COUNT:    cfg_rows  = 32'(value[CNT_W-1:0]);
            REG_COLUMN_COUNT: cfg_cols  = 32'(value[CNT_W-1:0]);
            REG_BLOCK_SIZE:   cfg_block = 32'(value[BS_W-1:0]);
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    // Receiver: random stalls, plus a long hold-off counted here when asked for.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Each result transfer is compared with the oldest outstanding read.
    always @(posedge clk)
    begin : check_reads
        y_read_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result: result_index %0d, result_value %0d",
                       rsp_ch.result_index, rsp_ch.result_value);
                fail_count++;
            end
            else
            begin
                want = pending_reads.pop_front();
                n_checked++;
                if (rsp_ch.result_index !== want.index)
                begin
                    $error("result_index: expected %0d, actual %0d",
                           want.index, rsp_ch.result_index);
                    fail_count++;
                end
                if (rsp_ch.result_value !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           want.value, rsp_ch.result_value);
                    fail_count++;
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #(12 * 400000);
        $display("csb_sparse_matvec_accumulate: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        spmv_req_t it;
        int unsigned rows;
        int unsigned cols;
        int unsigned blk;
        int unsigned rlim;
        int unsigned clim;
        int unsigned beta;
        int unsigned grow;
        int unsigned gcol;
        int unsigned span;
        int pick;
        int count;

        // Known values on every input from time zero.
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = '0;
        req_ch.vector_index = '0;
        req_ch.row_block = '0;
        req_ch.block_column = '0;
        req_ch.row_offset = '0;
        req_ch.local_column = '0;
        req_ch.data_value = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        fail_count = 0;
        n_loads = 0;
        n_accum = 0;
        n_reads = 0;
        n_unused = 0;
        n_dropped = 0;
        n_checked = 0;
        n_settings = 0;
        cfg_rows = 1;
        cfg_cols = 1;
        cfg_block = 1;
        for (int i = 0; i < DEF_MAX_COLS; i++)
            x_model[i] = '0;
        for (int i = 0; i < DEF_MAX_ROWS; i++)
            y_model[i] = '0;

        // Directed rows: extremes, saturation both ways, rounding, and the odd settings.
        directed.push_back(row_cfg(REG_ROW_COUNT, 4096));
        directed.push_back(row_cfg(REG_COLUMN_COUNT, 4096));
        directed.push_back(row_cfg(REG_BLOCK_SIZE, 64));
        directed.push_back(row_item(CMD_READ_Y, 0, 0, 0, 0, 0, 0, 1'b1, '0));
        directed.push_back(row_item(CMD_READ_Y, 4095, 0, 0, 0, 0, 0, 1'b1, '0));
        directed.push_back(row_item(CMD_UNUSED, 4095, 4095, 4095, 63, 63, 32'hFFFF_FFFF));
        directed.push_back(row_item(CMD_LOAD_X, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        directed.push_back(row_item(CMD_LOAD_X, 4095, 0, 0, 0, 0, 32'h8000_0000));
        directed.push_back(row_item(CMD_LOAD_X, 2, 0, 0, 0, 0, 32'h0000_0001));
        repeat (3)
            directed.push_back(row_item(CMD_ACCUM, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        directed.push_back(row_item(CMD_READ_Y, 0, 0, 0, 0, 0, 0, 1'b1, Y_SAT_HIGH));
        repeat (3)
            directed.push_back(row_item(CMD_ACCUM, 0, 0, 63, 1, 63, 32'h7FFF_FFFF));
        directed.push_back(row_item(CMD_READ_Y, 1, 0, 0, 0, 0, 0, 1'b1, Y_SAT_LOW));
        directed.push_back(row_item(CMD_ACCUM, 0, 0, 0, 3, 2, 32'hFFFF_FFFF));
        directed.push_back(row_item(CMD_READ_Y, 3, 0, 0, 0, 0, 0, 1'b1, Y_MINUS_ONE));
        directed.push_back(row_item(CMD_ACCUM, 0, 4095, 4095, 63, 63, 32'h1234_5678));
        // A block side above the largest is taken as the largest.
        directed.push_back(row_cfg(REG_BLOCK_SIZE, 127));
        directed.push_back(row_item(CMD_ACCUM, 0, 1, 0, 0, 0, 32'h0001_0000));
        directed.push_back(row_item(CMD_READ_Y, 64, 0, 0, 0, 0, 0));
        // A zero block side leaves only the local offsets.
        directed.push_back(row_cfg(REG_BLOCK_SIZE, 0));
        directed.push_back(row_item(CMD_ACCUM, 0, 4095, 4095, 5, 0, 32'h0001_0000));
        directed.push_back(row_item(CMD_READ_Y, 5, 0, 0, 0, 0, 0));
        // With no rows every nonzero is dropped.
        directed.push_back(row_cfg(REG_ROW_COUNT, 0));
        directed.push_back(row_item(CMD_ACCUM, 0, 0, 0, 0, 0, 32'h0001_0000));
        directed.push_back(row_item(CMD_READ_Y, 0, 0, 0, 0, 0, 0, 1'b1, '0));

        // Reset, once.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                cfg_write(directed[i].reg_idx, directed[i].reg_value);
            else
                offer(directed[i].item, directed[i].typed, directed[i].typed_value);
        end

        // Random phases, each with its own setting and idling pattern.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = 0;
            stall_pct = 0;
            case (phase)
                0:
                begin
                    rows = 4096;
                    cols = 4096;
                    blk = 64;
                end
                1:
                begin
                    rows = 8191;
                    cols = 8191;
                    blk = 127;
                end
                3:
                begin
                    rows = $urandom_range(1, 64);
                    cols = $urandom_range(1, 64);
                    blk = 0;
                end
                7:
                begin
                    rows = $urandom_range(1, 200);
                    cols = $urandom_range(1, 200);
                    blk = $urandom_range(65, 127);
                end
                default:
                begin
                    rows = $urandom_range(1, 80);
                    cols = $urandom_range(1, 80);
                    blk = $urandom_range(1, 12);
                end
            endcase
            cfg_write(REG_ROW_COUNT, rows);
            cfg_write(REG_COLUMN_COUNT, cols);
            cfg_write(REG_BLOCK_SIZE, blk);
            rlim = (rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows;
            clim = (cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols;
            beta = (blk > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : blk;

            case (phase % 4)
                1: send_idle_pct = 55;
                2: stall_pct = 55;
                3:
                begin
                    send_idle_pct = 28;
                    stall_pct = 28;
                end
                default:
                begin
                end
            endcase

            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                // Back-pressure: a long receiver hold-off, later a full drain.
                if (phase == 3 && count == 20 && hold_left == 0)
                    hold_left = LONG_HOLD;
                if (phase == 3 && count == 60)
                    drain_reads();

                it = '0;
                pick = $urandom_range(99);
                if (pick < 20)
                begin
                    span = ($urandom_range(99) < 80 && clim > 32) ? 32 : clim;
                    it.cmd = CMD_LOAD_X;
                    it.vector_index = IDX_W'($urandom_range(0, span - 1));
                    if ($urandom_range(99) < 40)
                        it.data_value = $urandom;
                    else
                        it.data_value = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
                end
                else if (pick < 65)
                begin
                    span = ($urandom_range(99) < 80 && rlim > 32) ? 32 : rlim;
                    grow = $urandom_range(0, span - 1);
                    span = ($urandom_range(99) < 80 && clim > 32) ? 32 : clim;
                    gcol = $urandom_range(0, span - 1);
                    it.cmd = CMD_ACCUM;
                    it.data_value = ($urandom_range(99) < 40) ? $urandom
                                    : $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    if (beta == 0)
                    begin
                        it.row_block = IDX_W'($urandom);
                        it.block_column = IDX_W'($urandom);
                        it.row_offset = grow[LOC_W-1:0];
                        it.local_column = gcol[LOC_W-1:0];
                    end
                    else
                    begin
                        it.row_block = IDX_W'(grow / beta);
                        it.row_offset = LOC_W'(grow % beta);
                        it.block_column = IDX_W'(gcol / beta);
                        it.local_column = LOC_W'(gcol % beta);
                        // Sometimes move a whole block into the local offset.
                        if ($urandom_range(99) < 15 && it.row_block != 0
                            && it.row_offset + beta < 64)
                        begin
                            it.row_block = it.row_block - 1'b1;
                            it.row_offset = LOC_W'(it.row_offset + beta);
                        end
                    end
                end
                else if (pick < 85)
                begin
                    span = ($urandom_range(99) < 80 && rlim > 32) ? 32 : rlim;
                    it.cmd = CMD_READ_Y;
                    it.vector_index = IDX_W'($urandom_range(0, span - 1));
                end
                else
                begin
                    // Noise: every field at random, the unused command included.
                    it.cmd = CMD_W'($urandom_range(0, 3));
                    it.vector_index = IDX_W'($urandom);
                    it.row_block = IDX_W'($urandom);
                    it.block_column = IDX_W'($urandom);
                    it.row_offset = LOC_W'($urandom);
                    it.local_column = LOC_W'($urandom);
                    it.data_value = $urandom;
                end
                offer(it, 1'b0, '0);
                if (it.cmd != CMD_UNUSED)
                    count++;
            end
        end

        // Wind down: all reads back, then a quiet spell before the report.
        send_idle_pct = 0;
        stall_pct = 0;
        drain_reads();
        repeat (20) @(negedge clk);

        $display("Run covered %0d x loads, %0d nonzeros (%0d outside the matrix), %0d y reads",
                 n_loads, n_accum, n_dropped, n_reads);
        $display("and %0d unused commands over %0d register writes; %0d results compared.",
                 n_unused, n_settings, n_checked);
        if (fail_count == 0)
            $display("csb_sparse_matvec_accumulate: match");
        else
            $display("csb_sparse_matvec_accumulate: mismatch");
        $finish;
    end

endmodule

[csb_sparse_matvec_accumulate.f]
rtl/core/csb_pkg.sv
rtl/core/csb_if.sv
rtl/core/csb_cfg.sv
rtl/core/csb_mac.sv
rtl/core/csb_sparse_matvec_accumulate.sv
rtl/core/csb_checker.sv
tb/csb_sparse_matvec_accumulate_tb.sv
